FILE: design/qrf_pkg.sv
// ----------------------------------------------------------------------------
// qrf_pkg
// Shared types and constants for the QR finder-pattern row run detector.
// ----------------------------------------------------------------------------
package qrf_pkg;

    localparam int MAX_ROW_WIDTH = 4096;

    localparam int ROW_W  = 12;
    localparam int RUN_W  = 13;
    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int END_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int ENDO_W = 13;
    localparam int CX_W   = 14;
    localparam int TOT_W  = 13;
    localparam int SUM_W  = 16;
    localparam int NRUNS  = 5;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef logic [RUN_W-1:0] run_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [END_W-1:0] end_col;
        run_t [NRUNS-1:0] runs;
        logic             from_row_end;
    } test_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cand_row;
        logic [ENDO_W-1:0] cand_end_column;
        logic [CX_W-1:0]   center_x_twice;
        logic [TOT_W-1:0]  total_width;
        logic [RUN_W-1:0]  center_run;
        logic              from_row_end;
    } result_t;

endpackage

FILE: design/qrf_front.sv
// ----------------------------------------------------------------------------
// qrf_front
// Tracks the five alternating runs of a row and queues a ratio test whenever
// the fifth run closes or the row ends.
// ----------------------------------------------------------------------------
module qrf_front
    import qrf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             pixel_black,
    input  logic [ROW_W-1:0] row_index,
    input  logic             row_end,
    input  logic             q_full,
    output logic             in_ready,
    output logic             push,
    output test_req_t        req
);

    run_t [NRUNS-1:0] runs_reg;
    run_t [NRUNS-1:0] runs_next;
    run_t [NRUNS-1:0] runs_upd;
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [2:0]       phase_upd;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             accept;
    logic             mid_test;
    logic             inc_en;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        runs_upd  = runs_reg;
        phase_upd = phase_reg;
        mid_test  = 1'b0;
        inc_en    = 1'b1;
        if (pixel_black)
        begin
            if (phase_reg[0])
            begin
                phase_upd = phase_reg + 3'd1;
            end
        end
        else if (!phase_reg[0])
        begin
            if (phase_reg == 3'd4)
            begin
                mid_test = 1'b1;
                inc_en   = 1'b0;
            end
            else
            begin
                phase_upd = phase_reg + 3'd1;
            end
        end
        if (mid_test)
        begin
            runs_upd[0] = runs_reg[2];
            runs_upd[1] = runs_reg[3];
            runs_upd[2] = runs_reg[4];
            runs_upd[3] = RUN_W'(1);
            runs_upd[4] = '0;
            phase_upd   = 3'd3;
        end
        else if (inc_en)
        begin
            for (int k = 0; k < NRUNS; k++)
            begin
                if (phase_upd == 3'(k) && runs_reg[k] != RUN_MAX)
                begin
                    runs_upd[k] = runs_reg[k] + RUN_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        req.row          = row_index;
        req.from_row_end = !mid_test;
        if (mid_test)
        begin
            req.runs    = runs_reg;
            req.end_col = END_W'(col_reg);
        end
        else
        begin
            req.runs    = runs_upd;
            req.end_col = END_W'(col_reg) + END_W'(1);
        end
        push = accept && (mid_test || row_end);
    end

    always_comb
    begin
        runs_next  = runs_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        if (accept)
        begin
            if (row_end)
            begin
                runs_next  = '0;
                phase_next = '0;
                col_next   = '0;
            end
            else
            begin
                runs_next  = runs_upd;
                phase_next = phase_upd;
                if (col_reg != COL_W'(MAX_ROW_WIDTH - 1))
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runs_reg  <= '0;
            phase_reg <= '0;
            col_reg   <= '0;
        end
        else
        begin
            runs_reg  <= runs_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
        end
    end

endmodule

FILE: design/qrf_queue.sv
// ----------------------------------------------------------------------------
// qrf_queue
// Short FIFO of pending ratio tests between the run tracker and the tester.
// ----------------------------------------------------------------------------
module qrf_queue
    import qrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  test_req_t push_req,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output test_req_t head_req
);

    test_req_t        mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_pop;

    assign full       = (count_reg == QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCW'(push) - QCW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/qrf_back.sv
// ----------------------------------------------------------------------------
// qrf_back
// Two-stage ratio tester: sums the runs, checks 1:1:3:1:1 within half a
// module (1.5 for the centre run), registers passing candidates for output.
// ----------------------------------------------------------------------------
module qrf_back
    import qrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  test_req_t head_req,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    localparam int SW = 20;

    test_req_t        s1_req_reg;
    logic [SUM_W-1:0] s1_total_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [SUM_W-1:0] total_sum;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_res_reg;
    result_t          res_calc;
    logic             out_ld;
    logic             s1_adv;
    logic             ok;
    logic signed [SW-1:0] t_s;
    logic signed [SW-1:0] s_s;
    logic signed [SW-1:0] d_s;
    logic signed [SW-1:0] cx_s;
    logic signed [SW-1:0] end_s;

    assign out_ld = !out_valid_reg || out_ready;
    assign s1_adv = s1_valid_reg && out_ld;
    assign pop    = head_valid && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        total_sum = '0;
        for (int k = 0; k < NRUNS; k++)
        begin
            total_sum = total_sum + SUM_W'(head_req.runs[k]);
        end
    end

    always_comb
    begin
        t_s = SW'(s1_total_reg);
        ok  = (t_s >= SW'(7));
        s_s = '0;
        d_s = '0;
        for (int k = 0; k < NRUNS; k++)
        begin
            s_s = SW'(s1_req_reg.runs[k]);
            if (s_s == '0)
            begin
                ok = 1'b0;
            end
            if (k == 2)
            begin
                d_s = (t_s <<< 2) + (t_s <<< 1) - ((s_s <<< 4) - (s_s <<< 1));
                if (d_s < 0)
                begin
                    d_s = -d_s;
                end
                if (!(d_s < (t_s <<< 1) + t_s))
                begin
                    ok = 1'b0;
                end
            end
            else
            begin
                d_s = (t_s <<< 1) - ((s_s <<< 4) - (s_s <<< 1));
                if (d_s < 0)
                begin
                    d_s = -d_s;
                end
                if (!(d_s < t_s))
                begin
                    ok = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        end_s = SW'(s1_req_reg.end_col);
        cx_s  = ((end_s - SW'(s1_req_reg.runs[4]) - SW'(s1_req_reg.runs[3])) <<< 1)
                - SW'(s1_req_reg.runs[2]);

        res_calc.cand_row     = s1_req_reg.row;
        res_calc.center_run   = s1_req_reg.runs[2];
        res_calc.from_row_end = s1_req_reg.from_row_end;

        if (end_s > SW'({ENDO_W{1'b1}}))
        begin
            res_calc.cand_end_column = {ENDO_W{1'b1}};
        end
        else
        begin
            res_calc.cand_end_column = end_s[ENDO_W-1:0];
        end

        if (cx_s < 0)
        begin
            res_calc.center_x_twice = '0;
        end
        else if (cx_s > SW'({CX_W{1'b1}}))
        begin
            res_calc.center_x_twice = {CX_W{1'b1}};
        end
        else
        begin
            res_calc.center_x_twice = cx_s[CX_W-1:0];
        end

        if (t_s > SW'({TOT_W{1'b1}}))
        begin
            res_calc.total_width = {TOT_W{1'b1}};
        end
        else
        begin
            res_calc.total_width = t_s[TOT_W-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_ld)
        begin
            out_valid_next = s1_valid_reg && ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_req_reg   <= head_req;
            s1_total_reg <= total_sum;
        end
        if (s1_adv)
        begin
            out_res_reg <= res_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: design/qr_finder_row_run_detector.sv
// Scans binarized image rows for the 1:1:3:1:1 black/white run pattern of a
// QR finder. One pixel transaction is taken every clock while the four-entry
// test queue has room; the queue fills only when the output stream stalls.
// A candidate reaches the output through the queue write, the registered run
// sum and the registered ratio check, in that order, after the transaction of
// the pixel that closes it; each pixel causes at most one.
// ----------------------------------------------------------------------------
// qr_finder_row_run_detector
// Top level: run tracker, test queue and ratio tester on stream ports.
// ----------------------------------------------------------------------------
module qr_finder_row_run_detector
    import qrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] pixel_black, [12:1] row_index, [15:13] zero
    input  logic        s_axis_tlast,   // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [11:0] cand_row, [24:12] cand_end_column,
                                        // [38:25] center_x_twice, [51:39] total_width,
                                        // [64:52] center_run, [71:65] zero
    output logic [0:0]  m_axis_tuser    // [0] from_row_end
);

    logic      q_full;
    logic      push;
    test_req_t push_req;
    logic      pop;
    logic      head_valid;
    test_req_t head_req;
    result_t   res;

    qrf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .pixel_black (s_axis_tdata[0]),
        .row_index   (s_axis_tdata[12:1]),
        .row_end     (s_axis_tlast),
        .q_full      (q_full),
        .in_ready    (s_axis_tready),
        .push        (push),
        .req         (push_req)
    );

    qrf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    qrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {7'd0, res.center_run, res.total_width, res.center_x_twice,
                           res.cand_end_column, res.cand_row};
    assign m_axis_tuser = res.from_row_end;

endmodule
